/* rtl/mcot_pkg.sv */
// Package: shared constants, request and response types for the compare timer.
package mcot_pkg;

   localparam int CHANNEL_COUNT = 8;
   localparam int COUNT_BITS = 16;
   localparam int CHAN_IDX_BITS = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_SERVICE = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  channel;
      logic [15:0] delay_count;
   } mcot_req_type;

   typedef struct packed {
      logic        start_accepted;
      logic [7:0]  serviced_mask;
      logic        interrupt_pending;
      logic [15:0] count_value;
   } mcot_rsp_type;

endpackage

/* rtl/multichannel_output_compare_timer_unit.sv */
// Top level: request register, timer core and response register.
// Eight-channel output compare timer on a 16-bit counter that advances on tick requests. Each
// request (tick, start or service) yields exactly one response, which passes from the request
// register to the response register; a new request is accepted every cycle while the response
// side does not stall.
// The mode mask register is written through the csr channel, which is always ready,
// and should be written only while no request is in flight.
module multichannel_output_compare_timer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mcot_pkg::mcot_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mcot_pkg::mcot_rsp_type rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import mcot_pkg::*;

   mcot_req_type req_ff;
   mcot_rsp_type rsp_ff, rsp_in;
   logic         req_valid_ff, req_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         req_take;

   assign advance = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   mcot_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req       (req_ff),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_in    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff)
      else $error("request stalled with free stage");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled response lost");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no response");

endmodule

/* rtl/mcot_core.sv */
// Core: counter, channel compare state and the single-pass request update.
module mcot_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  mcot_pkg::mcot_req_type req,
   input  logic                  csr_write,
   input  logic [7:0]            csr_data,
   output mcot_pkg::mcot_rsp_type rsp_in
);
   import mcot_pkg::*;

   localparam logic [3:0] CHANNEL_LIMIT = 4'(CHANNEL_COUNT);

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [COUNT_BITS-1:0]    compare_ff [CHANNEL_COUNT];
   logic [COUNT_BITS-1:0]    start_compare;
   logic [CHANNEL_COUNT-1:0] flags_ff, flags_in;
   logic [CHANNEL_COUNT-1:0] enables_ff, enables_in;
   logic [CHANNEL_COUNT-1:0] mode_ff;
   logic [CHANNEL_COUNT-1:0] hit;
   logic [CHANNEL_COUNT-1:0] serviced;
   logic [CHANNEL_COUNT-1:0] start_bit;
   logic                     start_ok;

   assign start_compare = count_ff + COUNT_BITS'(req.delay_count);

   always_comb begin
      count_in = count_ff;
      flags_in = flags_ff;
      enables_in = enables_ff;
      serviced = '0;
      start_bit = '0;
      start_ok = 1'b0;
      hit = '0;
      case (req.command)
         CMD_TICK: begin
            count_in = count_ff + 1'b1;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
               hit[c] = mode_ff[c] && (compare_ff[c] == count_in);
            end
            flags_in = flags_ff | hit;
         end
         CMD_START: begin
            if (req.channel < CHANNEL_LIMIT) begin
               start_ok = mode_ff[req.channel[CHAN_IDX_BITS-1:0]];
            end
            if (start_ok) begin
               start_bit[req.channel[CHAN_IDX_BITS-1:0]] = 1'b1;
            end
            flags_in = flags_ff & ~start_bit;
            enables_in = enables_ff | start_bit;
         end
         CMD_SERVICE: begin
            serviced = flags_ff & enables_ff;
            flags_in = flags_ff & ~serviced;
            enables_in = enables_ff & ~serviced;
         end
         default: begin
         end
      endcase
      rsp_in.start_accepted = start_ok;
      rsp_in.serviced_mask = 8'(serviced);
      rsp_in.interrupt_pending = |(flags_in & enables_in);
      rsp_in.count_value = 16'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flags_ff <= '0;
         enables_ff <= '0;
         mode_ff <= '0;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            compare_ff[c] <= '0;
         end
      end else begin
         if (csr_write) begin
            mode_ff <= CHANNEL_COUNT'(csr_data);
         end
         if (advance) begin
            count_ff <= count_in;
            flags_ff <= flags_in;
            enables_ff <= enables_in;
            if (start_ok) begin
               compare_ff[req.channel[CHAN_IDX_BITS-1:0]] <= start_compare;
            end
         end
      end
   end

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff) && $stable(flags_ff) && $stable(enables_ff))
      else $error("state changed without a request");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      advance && req.command == CMD_TICK |=> count_ff == $past(count_ff) + 1'b1)
      else $error("tick did not advance counter");

   a_irq_line: assert property (@(posedge clock) disable iff (reset)
      advance |=> (|(flags_ff & enables_ff)) == $past(rsp_in.interrupt_pending))
      else $error("interrupt line disagrees with state");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      advance && start_ok |=> (enables_ff & ~flags_ff & $past(start_bit)) == $past(start_bit))
      else $error("accepted start did not arm channel");

endmodule
